>>> rtl/core/idet_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package idet_pkg;

  // field widths fixed by the interface
  localparam int unsigned TimeInW = 48;
  localparam int unsigned UtilW   = 16;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegInputQuiet = 2'd0;
  localparam logic [CfgIdxW-1:0] RegUtilLimit  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSustain    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegStale      = 2'd3;

  // configuration reset values
  localparam logic [CfgW-1:0]  InputQuietRst = 32'd1000000;
  localparam logic [UtilW-1:0] UtilLimitRst  = 16'd6554;
  localparam logic [CfgW-1:0]  SustainRst    = 32'd2000000;
  localparam logic [CfgW-1:0]  StaleRst      = 32'd100000;

  // item kinds
  localparam logic FuncUpdate = 1'b0;
  localparam logic FuncUser   = 1'b1;

  typedef enum logic [1:0] {
    ModeActive   = 2'd0,
    ModePending  = 2'd1,
    ModeCooldown = 2'd2
  } mode_e;

  // decision for one beat, handed from the step logic to the state registers
  typedef struct packed {
    mode_e mode;
    logic  fire;
    logic  upd_prev;
    logic  upd_input;
    logic  upd_pending;
    logic  upd_fire;
  } step_t;

endpackage

`default_nettype wire

>>> rtl/core/idet_step.sv
`timescale 1ns / 1ps
`default_nettype none

module idet_step #(
  parameter int unsigned TIME_BITS = 48
) (
  input  wire logic                        func_i,
  input  wire logic [TIME_BITS-1:0]        now_i,
  input  wire logic [idet_pkg::UtilW-1:0]  util_i,
  input  wire idet_pkg::mode_e             mode_i,
  input  wire logic [TIME_BITS-1:0]        prev_update_i,
  input  wire logic [TIME_BITS-1:0]        last_input_i,
  input  wire logic [TIME_BITS-1:0]        pending_since_i,
  input  wire logic [TIME_BITS-1:0]        last_fire_i,
  input  wire logic [idet_pkg::CfgW-1:0]   input_quiet_i,
  input  wire logic [idet_pkg::UtilW-1:0]  util_limit_i,
  input  wire logic [idet_pkg::CfgW-1:0]   sustain_i,
  input  wire logic [idet_pkg::CfgW-1:0]   stale_i,
  output idet_pkg::step_t                  step_o
);

  // differences wrap modulo 2^TIME_BITS
  logic [TIME_BITS-1:0] gap_update;
  logic [TIME_BITS-1:0] gap_input;
  logic [TIME_BITS-1:0] gap_pending;
  logic [TIME_BITS-1:0] gap_fire;
  logic                 stale;
  logic                 qualified;
  logic                 pend_done;
  logic                 refire;

  assign gap_update  = now_i - prev_update_i;
  assign gap_input   = now_i - last_input_i;
  assign gap_pending = now_i - pending_since_i;
  assign gap_fire    = now_i - last_fire_i;

  assign stale     = gap_update > TIME_BITS'(stale_i);
  assign qualified = !stale && (gap_input > TIME_BITS'(input_quiet_i))
                     && (util_i < util_limit_i);
  assign pend_done = gap_pending >= TIME_BITS'(sustain_i);
  assign refire    = gap_fire >= TIME_BITS'(sustain_i);

  always_comb begin
    step_o             = '0;
    step_o.mode        = mode_i;
    if (func_i == idet_pkg::FuncUser) begin
      step_o.upd_input = 1'b1;
    end else begin
      step_o.upd_prev = 1'b1;
      if (!qualified) begin
        step_o.mode = idet_pkg::ModeActive;
      end else begin
        unique case (mode_i)
          idet_pkg::ModeActive: begin
            step_o.mode        = idet_pkg::ModePending;
            step_o.upd_pending = 1'b1;
          end
          idet_pkg::ModePending: begin
            if (pend_done) begin
              step_o.fire     = 1'b1;
              step_o.upd_fire = 1'b1;
              step_o.mode     = idet_pkg::ModeCooldown;
            end
          end
          default: begin
            // cooldown, and the unused code behaves the same
            if (refire) begin
              step_o.fire     = 1'b1;
              step_o.upd_fire = 1'b1;
            end
            step_o.mode = idet_pkg::ModeCooldown;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/idle_detector_fsm.sv
`timescale 1ns / 1ps
`default_nettype none

// path: a beat goes from the input register through the decision logic to the result register
// throughput: one beat per cycle while the result register is not held by out_ready_i
// the result register frees the input side whenever it is empty or being taken
// reset: mode active, update and input timestamps zero, registers at defaults
// pending and fire timestamps hold no reset value and are written before use
module idle_detector_fsm #(
  parameter int unsigned TIME_BITS = 48
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [idet_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [idet_pkg::CfgW-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          func_i,
  input  wire logic [idet_pkg::TimeInW-1:0]  time_now_i,
  input  wire logic [idet_pkg::UtilW-1:0]    util_sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               idle_fire_o,
  output logic [idet_pkg::UtilW-1:0]         fire_util_o,
  output logic                               is_idle_o,
  output logic [1:0]                         mode_out_o
);

  // configuration
  logic [idet_pkg::CfgW-1:0]  input_quiet_q;
  logic [idet_pkg::UtilW-1:0] util_limit_q;
  logic [idet_pkg::CfgW-1:0]  sustain_q;
  logic [idet_pkg::CfgW-1:0]  stale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      input_quiet_q <= idet_pkg::InputQuietRst;
      util_limit_q  <= idet_pkg::UtilLimitRst;
      sustain_q     <= idet_pkg::SustainRst;
      stale_q       <= idet_pkg::StaleRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        idet_pkg::RegInputQuiet: input_quiet_q <= cfg_data_i;
        idet_pkg::RegUtilLimit:  util_limit_q  <= cfg_data_i[idet_pkg::UtilW-1:0];
        idet_pkg::RegSustain:    sustain_q     <= cfg_data_i;
        idet_pkg::RegStale:      stale_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic                       in_valid_q;
  logic                       func_q;
  logic [TIME_BITS-1:0]       now_q;
  logic [idet_pkg::UtilW-1:0] util_q;
  logic                       advance;
  logic                       in_fire;
  logic                       step_go;

  assign advance    = !out_valid_o || out_ready_i;
  assign step_go    = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= func_i;
      now_q  <= TIME_BITS'(time_now_i);
      util_q <= util_sample_i;
    end
  end

  // detector state
  idet_pkg::mode_e      mode_q;
  logic [TIME_BITS-1:0] prev_update_q;
  logic [TIME_BITS-1:0] last_input_q;
  logic [TIME_BITS-1:0] pending_since_q;
  logic [TIME_BITS-1:0] last_fire_q;
  idet_pkg::step_t      step;

  idet_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .func_i          (func_q),
    .now_i           (now_q),
    .util_i          (util_q),
    .mode_i          (mode_q),
    .prev_update_i   (prev_update_q),
    .last_input_i    (last_input_q),
    .pending_since_i (pending_since_q),
    .last_fire_i     (last_fire_q),
    .input_quiet_i   (input_quiet_q),
    .util_limit_i    (util_limit_q),
    .sustain_i       (sustain_q),
    .stale_i         (stale_q),
    .step_o          (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= idet_pkg::ModeActive;
      prev_update_q <= '0;
      last_input_q  <= '0;
    end else if (step_go) begin
      mode_q <= step.mode;
      if (step.upd_prev) begin
        prev_update_q <= now_q;
      end
      if (step.upd_input) begin
        last_input_q <= now_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go && step.upd_pending) begin
      pending_since_q <= now_q;
    end
    if (step_go && step.upd_fire) begin
      last_fire_q <= now_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go) begin
      idle_fire_o <= step.fire;
      fire_util_o <= step.fire ? util_q : '0;
      is_idle_o   <= (step.mode != idet_pkg::ModeActive);
      mode_out_o  <= 2'(step.mode);
    end
  end

endmodule

`default_nettype wire
